>>> rtl/itoa_pkg.sv
package itoa_pkg;

    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_A     = 8'h61;
    localparam logic [7:0] CHAR_MINUS = 8'h2d;
    localparam logic [5:0] RADIX_MIN  = 6'd2;
    localparam logic [5:0] RADIX_MAX  = 6'd36;
    localparam logic [5:0] RADIX_DEC  = 6'd10;
    localparam logic [6:0] DEC_DIGITS = 7'd10;

    // floor(2^32 / r): the quotient estimate from it is exact or one low
    localparam logic [63:0] RECIP_NUM = 64'h1_0000_0000;
    localparam logic [31:0] RECIP_TABLE [0:63] = '{
        2:  32'(RECIP_NUM / 2),  3:  32'(RECIP_NUM / 3),  4:  32'(RECIP_NUM / 4),
        5:  32'(RECIP_NUM / 5),  6:  32'(RECIP_NUM / 6),  7:  32'(RECIP_NUM / 7),
        8:  32'(RECIP_NUM / 8),  9:  32'(RECIP_NUM / 9),  10: 32'(RECIP_NUM / 10),
        11: 32'(RECIP_NUM / 11), 12: 32'(RECIP_NUM / 12), 13: 32'(RECIP_NUM / 13),
        14: 32'(RECIP_NUM / 14), 15: 32'(RECIP_NUM / 15), 16: 32'(RECIP_NUM / 16),
        17: 32'(RECIP_NUM / 17), 18: 32'(RECIP_NUM / 18), 19: 32'(RECIP_NUM / 19),
        20: 32'(RECIP_NUM / 20), 21: 32'(RECIP_NUM / 21), 22: 32'(RECIP_NUM / 22),
        23: 32'(RECIP_NUM / 23), 24: 32'(RECIP_NUM / 24), 25: 32'(RECIP_NUM / 25),
        26: 32'(RECIP_NUM / 26), 27: 32'(RECIP_NUM / 27), 28: 32'(RECIP_NUM / 28),
        29: 32'(RECIP_NUM / 29), 30: 32'(RECIP_NUM / 30), 31: 32'(RECIP_NUM / 31),
        32: 32'(RECIP_NUM / 32), 33: 32'(RECIP_NUM / 33), 34: 32'(RECIP_NUM / 34),
        35: 32'(RECIP_NUM / 35), 36: 32'(RECIP_NUM / 36),
        default: 32'd0
    };

    typedef struct packed {
        logic signed [31:0] value;
        logic [5:0]         radix;
        logic [5:0]         min_digits;
    } item_t;

    typedef struct packed {
        logic [7:0] character;
        logic       last;
        logic [5:0] length;
    } text_t;

    typedef struct packed {
        logic [31:0] mag;
        logic [5:0]  radix;
        logic [31:0] recip;
        logic [5:0]  mind;
        logic        neg;
    } job_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_FIX,
        ST_SIGN,
        ST_READ,
        ST_SEND
    } back_state_t;

    function automatic logic [7:0] digit_char(input logic [6:0] d);
        logic [7:0] c;
        if (d < DEC_DIGITS)
            c = CHAR_ZERO + 8'(d);
        else
            c = CHAR_A + 8'(d - DEC_DIGITS);
        return c;
    endfunction

endpackage

>>> rtl/itoa_front.sv
module itoa_front #(
    parameter int MAX_DIGITS = 32
) (
    input  itoa_pkg::item_t item,
    output itoa_pkg::job_t  job
);
    import itoa_pkg::*;

    logic [5:0] radix_c;

    // clamp radix into 2..36
    always_comb
    begin
        if (item.radix < RADIX_MIN)
            radix_c = RADIX_MIN;
        else if (item.radix > RADIX_MAX)
            radix_c = RADIX_MAX;
        else
            radix_c = item.radix;
    end

    always_comb
    begin
        job.radix = radix_c;
        job.recip = RECIP_TABLE[radix_c];
        job.neg   = (radix_c == RADIX_DEC) && item.value[31];
        job.mag   = job.neg ? (32'd0 - 32'(item.value)) : 32'(item.value);
        if (int'(item.min_digits) > MAX_DIGITS)
            job.mind = 6'(MAX_DIGITS);
        else
            job.mind = item.min_digits;
    end

endmodule

>>> rtl/itoa_queue.sv
module itoa_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  itoa_pkg::job_t push_job,
    output logic           full,
    input  logic           pop,
    output logic           not_empty,
    output itoa_pkg::job_t pop_job
);
    import itoa_pkg::*;

    job_t       entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign pop_job   = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_job;
    end

endmodule

>>> rtl/itoa_back.sv
module itoa_back #(
    parameter int MAX_DIGITS = 32
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            job_valid,
    input  itoa_pkg::job_t  job,
    output logic            job_pop,
    output logic            text_valid,
    input  logic            text_ready,
    output itoa_pkg::text_t text
);
    import itoa_pkg::*;

    localparam int CAP  = (MAX_DIGITS > 32) ? MAX_DIGITS : 32;
    localparam int IDXW = $clog2(CAP);
    localparam int NDW  = $clog2(CAP + 1);

    back_state_t    state_reg, state_next;
    logic [31:0]    quo_reg, quo_next;
    logic [31:0]    qe_reg;
    logic [5:0]     radix_reg;
    logic [31:0]    recip_reg;
    logic [5:0]     mind_reg;
    logic           neg_reg;
    logic [NDW-1:0] nd_reg, nd_next;
    logic [NDW-1:0] k_reg, k_next;
    logic [7:0]     rdata_reg;
    text_t          text_reg, text_next;
    logic           text_valid_reg, text_valid_next;
    logic [7:0]     buf_mem [CAP];

    logic [63:0]    prod;
    logic [31:0]    diff;
    logic [6:0]     rem;
    logic           rem_big;
    logic [31:0]    q_fix;
    logic [6:0]     digit;
    logic [NDW-1:0] nd_inc;
    logic           conv_done;
    logic           slot_free;
    logic           load_job;
    logic           wr_en;
    logic           load_sign;
    logic           load_digit;
    logic           is_last;
    logic [NDW-1:0] rd_pos;
    logic [5:0]     length;

    assign prod      = 64'(quo_reg) * 64'(recip_reg);
    assign diff      = quo_reg - 32'(qe_reg * 32'(radix_reg));
    assign rem       = diff[6:0];
    assign rem_big   = (rem >= 7'(radix_reg));
    assign q_fix     = rem_big ? (qe_reg + 32'd1) : qe_reg;
    assign digit     = rem_big ? (rem - 7'(radix_reg)) : rem;
    assign nd_inc    = nd_reg + NDW'(1);
    assign conv_done = ((q_fix == 32'd0) && (nd_inc >= NDW'(mind_reg)))
                       || (nd_inc == NDW'(CAP));
    assign slot_free = !text_valid_reg || text_ready;
    assign is_last   = (k_reg == nd_reg - NDW'(1));
    assign rd_pos    = nd_reg - NDW'(1) - k_reg;
    assign length    = 6'(nd_reg + NDW'(neg_reg));

    assign text_valid = text_valid_reg;
    assign text       = text_reg;
    assign job_pop    = load_job;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (job_valid) state_next = ST_MUL;
            ST_MUL:  state_next = ST_FIX;
            ST_FIX:
            begin
                if (!conv_done)
                    state_next = ST_MUL;
                else if (neg_reg)
                    state_next = ST_SIGN;
                else
                    state_next = ST_READ;
            end
            ST_SIGN: if (slot_free) state_next = ST_READ;
            ST_READ: state_next = ST_SEND;
            ST_SEND:
            begin
                if (slot_free)
                    state_next = is_last ? ST_IDLE : ST_READ;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath controls
    always_comb
    begin
        load_job   = (state_reg == ST_IDLE) && job_valid;
        wr_en      = (state_reg == ST_FIX);
        load_sign  = (state_reg == ST_SIGN) && slot_free;
        load_digit = (state_reg == ST_SEND) && slot_free;

        quo_next = quo_reg;
        nd_next  = nd_reg;
        k_next   = k_reg;
        if (load_job)
        begin
            quo_next = job.mag;
            nd_next  = '0;
        end
        else if (wr_en)
        begin
            quo_next = q_fix;
            nd_next  = nd_inc;
            k_next   = '0;
        end
        else if (load_digit)
        begin
            k_next = k_reg + NDW'(1);
        end

        text_next       = text_reg;
        text_valid_next = text_valid_reg && !text_ready;
        if (load_sign)
        begin
            text_next       = '{character: CHAR_MINUS, last: 1'b0, length: length};
            text_valid_next = 1'b1;
        end
        else if (load_digit)
        begin
            text_next       = '{character: rdata_reg, last: is_last, length: length};
            text_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            text_valid_reg <= 1'b0;
            quo_reg        <= '0;
            nd_reg         <= '0;
            k_reg          <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            text_valid_reg <= text_valid_next;
            quo_reg        <= quo_next;
            nd_reg         <= nd_next;
            k_reg          <= k_next;
        end
    end

    always_ff @(posedge clk)
    begin
        text_reg <= text_next;
        if (state_reg == ST_MUL)
            qe_reg <= prod[63:32];
        if (load_job)
        begin
            radix_reg <= job.radix;
            recip_reg <= job.recip;
            mind_reg  <= job.mind;
            neg_reg   <= job.neg;
        end
    end

    // digit store: written least significant first, read back in reverse
    always_ff @(posedge clk)
    begin
        if (wr_en)
            buf_mem[nd_reg[IDXW-1:0]] <= digit_char(digit);
        if (state_reg == ST_READ)
            rdata_reg <= buf_mem[rd_pos[IDXW-1:0]];
    end

endmodule

>>> rtl/integer_to_ascii_radix.sv
// Integer to ASCII text converter, radix 2 to 36.
// Input channel (item_valid / item_ready / item): one beat carries a 32-bit
// value, a radix (0 and 1 act as 2, above 36 acts as 36) and a minimum digit
// count (saturating at MAX_DIGITS). Only radix ten prints the value signed.
// Output channel (text_valid / text_ready / text): one beat per character,
// most significant first, lower-case letters for digits above nine, a
// leading '-' for a negative decimal value, zero padding up to the minimum
// count. Every beat carries the total length; the final one has last set.
// Operation: for each digit the divide unit does a 32x32 reciprocal
// multiply, then a correct-and-store step; each character is then read
// back from the digit store and handed to the output register.
// A two-entry queue sits between the input classifier and the converter,
// so up to two further items are taken while one is being worked on.
// When the receiver stalls, the output register holds its beat and the
// converter waits; the queue fills and then item_ready drops.
// Reset clears the queue, the converter state and the output valid flag.
module integer_to_ascii_radix #(
    parameter int MAX_DIGITS = 32
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            item_valid,
    output logic            item_ready,
    input  itoa_pkg::item_t item,
    output logic            text_valid,
    input  logic            text_ready,
    output itoa_pkg::text_t text
);
    import itoa_pkg::*;

    job_t front_job;
    job_t queued_job;
    logic queue_full;
    logic queue_has_job;
    logic queue_pop;
    logic item_beat;

    // accept whenever the queue has room
    assign item_ready = !queue_full;
    assign item_beat  = item_valid && item_ready;

    // clamp radix and minimum count, take the decimal magnitude, look up
    // the reciprocal for the divide unit
    itoa_front #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_front (
        .item (item),
        .job  (front_job)
    );

    itoa_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (item_beat),
        .push_job  (front_job),
        .full      (queue_full),
        .pop       (queue_pop),
        .not_empty (queue_has_job),
        .pop_job   (queued_job)
    );

    // divide into the digit store, then stream characters out
    itoa_back #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .job_valid  (queue_has_job),
        .job        (queued_job),
        .job_pop    (queue_pop),
        .text_valid (text_valid),
        .text_ready (text_ready),
        .text       (text)
    );

endmodule
